FILE: rtl/core/rru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_pkg : shared types and constants for the ray refraction unit
// Fixed-point formats, internal widths and the side-band beat struct.
// ----------------------------------------------------------------------------
package rru_pkg;

   localparam int CompWidth  = 16;  // Q4.12 component
   localparam int FracBits   = 12;
   localparam int Half       = 1 << (FracBits - 1);

   localparam int ProdWidth  = 33;  // n * (-d)
   localparam int DotWidth   = 35;  // sum of three products
   localparam int CosWidth   = 23;
   localparam int CnWidth    = 39;  // cos * n
   localparam int SumWidth   = 28;  // d + cos*n
   localparam int RsWidth    = 45;  // ratio * s
   localparam int RqWidth    = 33;  // ratio * s, rounded
   localparam int PerpWidth  = 31;  // inner saturation width
   localparam int SqWidth    = 62;  // |perp|^2
   localparam int RootWidth  = 31;
   localparam int RemWidth   = 35;
   localparam int PrWidth    = 48;  // root * n
   localparam int ParWidth   = 36;
   localparam int OutWidth   = 37;

   localparam int PerpMax    = (1 << (PerpWidth - 1)) - 1;
   localparam int CompMax    = (1 << (CompWidth - 1)) - 1;

   typedef logic signed [CompWidth-1:0] comp_type;
   typedef logic signed [PerpWidth-1:0] perp_type;

   // travels alongside the square root pipeline
   typedef struct packed {
      perp_type perp_x;
      perp_type perp_y;
      perp_type perp_z;
      comp_type norm_x;
      comp_type norm_y;
      comp_type norm_z;
      logic     sat;
   } rru_side_type;

endpackage

FILE: rtl/core/rru_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_front : cosine, perpendicular term and |1 - |perp|^2|
// Eight register stages, one multiply or one wide add per stage.
// ----------------------------------------------------------------------------
module rru_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  rru_pkg::comp_type         dir_x,
   input  rru_pkg::comp_type         dir_y,
   input  rru_pkg::comp_type         dir_z,
   input  rru_pkg::comp_type         norm_x,
   input  rru_pkg::comp_type         norm_y,
   input  rru_pkg::comp_type         norm_z,
   input  logic [15:0]               index_ratio,
   output logic                      out_valid,
   output logic [rru_pkg::SqWidth-1:0] out_mag,
   output rru_pkg::rru_side_type     out_side
);
   import rru_pkg::*;

   logic [7:0] valid_ff;

   comp_type d_in [3];
   comp_type n_in [3];

   // stage 1
   logic signed [ProdWidth-1:0] p_ff [3];
   comp_type d1_ff [3], n1_ff [3];
   logic [CompWidth-1:0] r1_ff;
   // stage 2
   logic signed [CosWidth-1:0] cos_ff;
   comp_type d2_ff [3], n2_ff [3];
   logic [CompWidth-1:0] r2_ff;
   // stage 3
   logic signed [CnWidth-1:0] cn_ff [3];
   comp_type d3_ff [3], n3_ff [3];
   logic [CompWidth-1:0] r3_ff;
   // stage 4
   logic signed [SumWidth-1:0] s_ff [3];
   comp_type n4_ff [3];
   logic [CompWidth-1:0] r4_ff;
   // stage 5
   logic signed [RsWidth-1:0] rs_ff [3];
   comp_type n5_ff [3];
   // stage 6
   perp_type perp6_ff [3];
   comp_type n6_ff [3];
   logic     sat6_ff;
   // stage 7
   logic [SqWidth-1:0] sq_ff [3];
   perp_type perp7_ff [3];
   comp_type n7_ff [3];
   logic     sat7_ff;
   // stage 8
   logic [SqWidth-1:0] mag_ff;
   rru_side_type side_ff;

   logic signed [DotWidth-1:0] psum;
   logic signed [CosWidth-1:0] dot_in;
   logic signed [CosWidth-1:0] cos_in;
   perp_type perp_in [3];
   logic     sat_in;
   logic [SqWidth-1:0] lsq;
   logic [SqWidth-1:0] mag_in;
   logic signed [RqWidth-1:0] rq [3];

   assign d_in = '{dir_x, dir_y, dir_z};
   assign n_in = '{norm_x, norm_y, norm_z};

   always_comb begin
      psum   = DotWidth'(p_ff[0]) + DotWidth'(p_ff[1]) + DotWidth'(p_ff[2]);
      dot_in = CosWidth'((psum + DotWidth'(Half)) >>> FracBits);
      cos_in = (dot_in < CosWidth'(1 << FracBits)) ? dot_in : CosWidth'(1 << FracBits);
   end

   // round ratio*s and clamp to the inner width
   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rq[i] = RqWidth'((rs_ff[i] + RsWidth'(Half)) >>> FracBits);
         if (rq[i] > RqWidth'(PerpMax)) begin
            perp_in[i] = PerpWidth'(PerpMax);
            sat_in     = 1'b1;
         end else if (rq[i] < -RqWidth'(PerpMax) - RqWidth'(1)) begin
            perp_in[i] = -PerpWidth'(PerpMax) - PerpWidth'(1);
            sat_in     = 1'b1;
         end else begin
            perp_in[i] = PerpWidth'(rq[i]);
         end
      end
   end

   always_comb begin
      lsq    = sq_ff[0] + sq_ff[1] + sq_ff[2];
      mag_in = (lsq >= (SqWidth'(1) << (2 * FracBits))) ?
               lsq - (SqWidth'(1) << (2 * FracBits)) :
               (SqWidth'(1) << (2 * FracBits)) - lsq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i]  <= n_in[i] * ((CompWidth+1)'(0) - (CompWidth+1)'(d_in[i]));
            d1_ff[i] <= d_in[i];
            n1_ff[i] <= n_in[i];
            d2_ff[i] <= d1_ff[i];
            n2_ff[i] <= n1_ff[i];
            cn_ff[i] <= cos_ff * n2_ff[i];
            d3_ff[i] <= d2_ff[i];
            n3_ff[i] <= n2_ff[i];
            s_ff[i]  <= SumWidth'(d3_ff[i]) +
                        SumWidth'((cn_ff[i] + CnWidth'(Half)) >>> FracBits);
            n4_ff[i] <= n3_ff[i];
            rs_ff[i] <= $signed({1'b0, r4_ff}) * s_ff[i];
            n5_ff[i] <= n4_ff[i];
            perp6_ff[i] <= perp_in[i];
            n6_ff[i] <= n5_ff[i];
            // full-width square, widened before the multiply
            sq_ff[i] <= $unsigned(SqWidth'(perp6_ff[i]) * SqWidth'(perp6_ff[i]));
            perp7_ff[i] <= perp6_ff[i];
            n7_ff[i] <= n6_ff[i];
         end
         r1_ff   <= index_ratio;
         cos_ff  <= cos_in;
         r2_ff   <= r1_ff;
         r3_ff   <= r2_ff;
         r4_ff   <= r3_ff;
         sat6_ff <= sat_in;
         sat7_ff <= sat6_ff;
         mag_ff  <= mag_in;
         side_ff <= '{perp_x: perp7_ff[0], perp_y: perp7_ff[1], perp_z: perp7_ff[2],
                      norm_x: n7_ff[0], norm_y: n7_ff[1], norm_z: n7_ff[2],
                      sat: sat7_ff};
      end
   end

   assign out_valid = valid_ff[7];
   assign out_mag   = mag_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/core/rru_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_sqrt : pipelined floor integer square root
// One root bit per stage, restoring digit recurrence on a remainder.
// ----------------------------------------------------------------------------
module rru_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [rru_pkg::SqWidth-1:0]  in_mag,
   input  rru_pkg::rru_side_type        in_side,
   output logic                         out_valid,
   output logic [rru_pkg::RootWidth-1:0] out_root,
   output rru_pkg::rru_side_type        out_side
);
   import rru_pkg::*;

   localparam int Stages = RootWidth;

   logic                 valid_ff [Stages];
   logic [SqWidth-1:0]   mag_ff   [Stages];
   logic [RemWidth-1:0]  rem_ff   [Stages];
   logic [RootWidth-1:0] root_ff  [Stages];
   rru_side_type         side_ff  [Stages];

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      logic                 v_prev;
      logic [SqWidth-1:0]   m_prev;
      logic [RemWidth-1:0]  rem_prev;
      logic [RootWidth-1:0] root_prev;
      rru_side_type         side_prev;
      logic [RemWidth-1:0]  rem_sh;
      logic [RemWidth-1:0]  trial;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign m_prev    = in_mag;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign m_prev    = mag_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign rem_sh = {rem_prev[RemWidth-3:0], m_prev[SqWidth-1-2*k -: 2]};
      assign trial  = {(RemWidth-2)'(root_prev), 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff[k]  <= m_prev;
            side_ff[k] <= side_prev;
            if (rem_sh >= trial) begin
               rem_ff[k]  <= rem_sh - trial;
               root_ff[k] <= {root_prev[RootWidth-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_sh;
               root_ff[k] <= {root_prev[RootWidth-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign out_root  = root_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];

   a_root_low: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (64'(out_root) * 64'(out_root)) <= 64'(mag_ff[Stages-1]))
      else $error("sqrt root too large");

   a_root_high: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ((64'(out_root) + 64'd1) * (64'(out_root) + 64'd1)) >
                    64'(mag_ff[Stages-1]))
      else $error("sqrt root too small");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(out_valid))
      else $error("sqrt pipe moved during stall");

endmodule

FILE: rtl/core/rru_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_back : parallel term and output saturation
// Stage one multiplies root by the normal, stage two rounds, subtracts, clamps.
// ----------------------------------------------------------------------------
module rru_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rru_pkg::RootWidth-1:0] in_root,
   input  rru_pkg::rru_side_type         in_side,
   output logic                          out_valid,
   output rru_pkg::comp_type             out_x,
   output rru_pkg::comp_type             out_y,
   output rru_pkg::comp_type             out_z,
   output logic                          out_sat
);
   import rru_pkg::*;

   logic [1:0] valid_ff;
   logic signed [PrWidth-1:0] pr_ff [3];
   perp_type perp_ff [3];
   logic     sat1_ff;
   comp_type o_ff [3];
   logic     sat2_ff;

   comp_type n_in [3];
   perp_type p_in [3];
   logic signed [ParWidth-1:0] par [3];
   logic signed [OutWidth-1:0] sum [3];
   comp_type o_in [3];
   logic     sat_in;

   assign n_in = '{in_side.norm_x, in_side.norm_y, in_side.norm_z};
   assign p_in = '{in_side.perp_x, in_side.perp_y, in_side.perp_z};

   always_comb begin
      sat_in = sat1_ff;
      for (int i = 0; i < 3; i++) begin
         par[i] = ParWidth'((pr_ff[i] + PrWidth'(Half)) >>> FracBits);
         sum[i] = OutWidth'(perp_ff[i]) - OutWidth'(par[i]);
         if (sum[i] > OutWidth'(CompMax)) begin
            o_in[i] = CompWidth'(CompMax);
            sat_in  = 1'b1;
         end else if (sum[i] < -OutWidth'(CompMax) - OutWidth'(1)) begin
            o_in[i] = -CompWidth'(CompMax) - CompWidth'(1);
            sat_in  = 1'b1;
         end else begin
            o_in[i] = CompWidth'(sum[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pr_ff[i]   <= $signed({1'b0, in_root}) * n_in[i];
            perp_ff[i] <= p_in[i];
            o_ff[i]    <= o_in[i];
         end
         sat1_ff <= in_side.sat;
         sat2_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_x     = o_ff[0];
   assign out_y     = o_ff[1];
   assign out_z     = o_ff[2];
   assign out_sat   = sat2_ff;

endmodule

FILE: rtl/core/ray_refraction_unit.sv
`timescale 1ns / 1ps
// An accepted req beat passes the front, square root and back stages in order to rsp_valid.
// Throughput: one beat per cycle while rsp is not stalled; the 31-stage square root sets the depth.
// The whole pipe advances together; it holds only while rsp stalls.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// ray_refraction_unit : vector Snell refraction, fixed point Q4.12
// cos = min(n.-d, 1); perp = r(d + cos n); out = perp - sqrt|1-|perp|^2| n.
// ----------------------------------------------------------------------------
module ray_refraction_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rru_pkg::comp_type req_dir_x,
   input  rru_pkg::comp_type req_dir_y,
   input  rru_pkg::comp_type req_dir_z,
   input  rru_pkg::comp_type req_norm_x,
   input  rru_pkg::comp_type req_norm_y,
   input  rru_pkg::comp_type req_norm_z,
   input  logic [15:0]       req_index_ratio,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rru_pkg::comp_type rsp_out_x,
   output rru_pkg::comp_type rsp_out_y,
   output rru_pkg::comp_type rsp_out_z,
   output logic              rsp_saturated
);
   import rru_pkg::*;

   // global advance: the last stage is the output register
   logic en;

   logic                 f_valid;
   logic [SqWidth-1:0]   f_mag;
   rru_side_type         f_side;
   logic                 s_valid;
   logic [RootWidth-1:0] s_root;
   rru_side_type         s_side;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // front end: dot product, cos clamp, perp, |perp|^2, magnitude
   rru_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .dir_x       (req_dir_x),
      .dir_y       (req_dir_y),
      .dir_z       (req_dir_z),
      .norm_x      (req_norm_x),
      .norm_y      (req_norm_y),
      .norm_z      (req_norm_z),
      .index_ratio (req_index_ratio),
      .out_valid   (f_valid),
      .out_mag     (f_mag),
      .out_side    (f_side)
   );

   // one root bit per stage
   rru_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_mag    (f_mag),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // parallel term, final sum and clamp
   rru_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_side   (s_side),
      .out_valid (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .out_sat   (rsp_saturated)
   );

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !f_valid && !s_valid)
      else $error("valid bits not cleared by reset");

   a_hold_mid: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(f_valid) && $stable(s_valid))
      else $error("pipe moved during stall");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) &&
         $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_saturated))
      else $error("rsp beat changed while stalled");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for the ray refraction unit
// A directed table and then random rays are driven through valid/ready with
// random idling on both sides. A bit-exact refraction predictor, or the table's
// own value for known rows, checks every response beat in order.
// ----------------------------------------------------------------------------
module testbench;

   import rru_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int RandomRays = 1040;
   localparam int DrainWait  = 80;   // pipe depth is 41, plus margin

   typedef struct {
      comp_type    dx, dy, dz;
      comp_type    nx, ny, nz;
      logic [15:0] ratio;
   } ray_type;

   typedef struct {
      comp_type ox, oy, oz;
      logic     sat;
   } bent_type;

   typedef struct {
      ray_type  ray;
      bit       known;
      bent_type bent;
   } table_row_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   comp_type req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   comp_type req_norm_x = '0, req_norm_y = '0, req_norm_z = '0;
   logic [15:0] req_index_ratio = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   comp_type rsp_out_x, rsp_out_y, rsp_out_z;
   logic     rsp_saturated;

   bent_type      bent_queue[$];
   table_row_type rows[$];
   int  mismatches = 0;
   int  cycles = 0;
   int  send_idle = 0;
   int  recv_stall = 0;
   logic hold_rsp = 1'b0;

   ray_refraction_unit dut (
      .clock, .reset,
      .req_valid, .req_ready,
      .req_dir_x, .req_dir_y, .req_dir_z,
      .req_norm_x, .req_norm_y, .req_norm_z,
      .req_index_ratio,
      .rsp_valid, .rsp_ready,
      .rsp_out_x, .rsp_out_y, .rsp_out_z,
      .rsp_saturated
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---- refraction predictor ----

   function automatic longint round_frac(longint p);
      return (p + Half) >>> FracBits;
   endfunction

   function automatic longint clamp_bits(longint v, int bits, inout bit flag);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         flag = 1'b1;
         return hi;
      end
      if (v < lo) begin
         flag = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // floor integer square root, digit by digit
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bent_type refract(ray_type ray);
      longint d[3], n[3], perp[3], o[3];
      longint ratio, dot, cosq, s;
      longint unsigned len_sq, one_sq, mag, root;
      bit flag;
      bent_type res;
      d = '{ray.dx, ray.dy, ray.dz};
      n = '{ray.nx, ray.ny, ray.nz};
      ratio = longint'(ray.ratio);
      flag = 1'b0;
      // exact dot of n and -d, rounded once
      dot = round_frac(-(n[0] * d[0]) - (n[1] * d[1]) - (n[2] * d[2]));
      cosq = (dot < (longint'(1) <<< FracBits)) ? dot : (longint'(1) <<< FracBits);
      cosq = clamp_bits(cosq, PerpWidth, flag);
      len_sq = 0;
      for (int i = 0; i < 3; i++) begin
         s = clamp_bits(d[i] + round_frac(cosq * n[i]), PerpWidth, flag);
         perp[i] = clamp_bits(round_frac(ratio * s), PerpWidth, flag);
         len_sq += longint'(perp[i] * perp[i]);
      end
      one_sq = 64'd1 << (2 * FracBits);
      mag = (len_sq >= one_sq) ? len_sq - one_sq : one_sq - len_sq;
      root = floor_sqrt(mag);
      for (int i = 0; i < 3; i++)
         o[i] = clamp_bits(perp[i] - round_frac(longint'(root) * n[i]), CompWidth, flag);
      res.ox = comp_type'(o[0]);
      res.oy = comp_type'(o[1]);
      res.oz = comp_type'(o[2]);
      res.sat = flag;
      return res;
   endfunction

   // ---- stimulus helpers ----

   function automatic ray_type make_ray(int dx, int dy, int dz, int nx, int ny, int nz,
                                        int r);
      ray_type ray;
      ray.dx = comp_type'(dx);
      ray.dy = comp_type'(dy);
      ray.dz = comp_type'(dz);
      ray.nx = comp_type'(nx);
      ray.ny = comp_type'(ny);
      ray.nz = comp_type'(nz);
      ray.ratio = 16'(r);
      return ray;
   endfunction

   function automatic void add_row(ray_type ray, bit known, int ox, int oy, int oz,
                                   bit sat);
      table_row_type row;
      row.ray = ray;
      row.known = known;
      row.bent.ox = comp_type'(ox);
      row.bent.oy = comp_type'(oy);
      row.bent.oz = comp_type'(oz);
      row.bent.sat = sat;
      rows.push_back(row);
   endfunction

   // roughly unit vector, Q4.12; floor keeps the last square root argument >= 0
   function automatic void unit_vec(output int x, output int y, output int z);
      int lim;
      x = int'($urandom_range(8192)) - 4096;
      lim = int'($floor($sqrt(real'(16777216 - x * x))));
      y = int'($urandom_range(2 * lim)) - lim;
      z = int'($sqrt(real'(16777216 - x * x - y * y)));
      if ($urandom_range(1)) z = -z;
   endfunction

   function automatic ray_type random_ray();
      ray_type ray;
      int dx, dy, dz, nx, ny, nz, r;
      int kind;
      kind = $urandom_range(9);
      if (kind <= 6) begin
         unit_vec(dx, dy, dz);
         unit_vec(nx, ny, nz);
         // usually the ray hits the front of the surface
         if (dx * nx + dy * ny + dz * nz > 0 && $urandom_range(9) < 8) begin
            dx = -dx;
            dy = -dy;
            dz = -dz;
         end
      end else if (kind <= 8) begin
         dx = $urandom; dy = $urandom; dz = $urandom;
         nx = $urandom; ny = $urandom; nz = $urandom;
      end else begin
         dx = int'($urandom_range(1023)) - 512; dy = int'($urandom_range(1023)) - 512;
         dz = int'($urandom_range(1023)) - 512; nx = int'($urandom_range(1023)) - 512;
         ny = int'($urandom_range(1023)) - 512; nz = int'($urandom_range(1023)) - 512;
      end
      r = ($urandom_range(9) < 7) ? $urandom_range(8192, 2048) : $urandom_range(65535);
      ray = make_ray(dx, dy, dz, nx, ny, nz, r);
      return ray;
   endfunction

   // one request beat; blocks until accepted
   task automatic send_ray(ray_type ray, bit known, bent_type typed);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dir_x <= ray.dx;
      req_dir_y <= ray.dy;
      req_dir_z <= ray.dz;
      req_norm_x <= ray.nx;
      req_norm_y <= ray.ny;
      req_norm_z <= ray.nz;
      req_index_ratio <= ray.ratio;
      do @(posedge clock); while (!req_ready);
      bent_queue.push_back(known ? typed : refract(ray));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (bent_queue.size() != 0) @(posedge clock);
   endtask

   task automatic hold_off(int n);
      hold_rsp <= 1'b1;
      repeat (n) @(posedge clock);
      hold_rsp <= 1'b0;
   endtask

   // ---- response checking ----

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      bent_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bent_queue.size() == 0) begin
               $error("response beat with nothing expected");
               mismatches++;
            end else begin
               want = bent_queue.pop_front();
               check_field("out_x", want.ox, rsp_out_x);
               check_field("out_y", want.oy, rsp_out_y);
               check_field("out_z", want.oz, rsp_out_z);
               check_field("saturated", want.sat, rsp_saturated);
            end
         end
         rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_stall);
      end
   end

   // ---- main sequence ----

   initial begin
      bent_type none;
      int idle_set[4] = '{0, 50, 0, 29};
      int stall_set[4] = '{0, 0, 50, 29};
      none = '{default: '0};

      // all zero: perp vanishes, root is one, normal is zero
      add_row(make_ray(0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
      // straight down onto the surface, ratio one
      add_row(make_ray(0, 0, -4096, 0, 0, 4096, 4096), 1, 0, 0, -4096, 0);
      // zero ratio: only the parallel term survives
      add_row(make_ray(4096, 0, 0, -4096, 0, 0, 0), 1, 4096, 0, 0, 0);
      // extremes of every field
      add_row(make_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535), 0, 0, 0, 0, 0);
      add_row(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535),
              0, 0, 0, 0, 0);
      add_row(make_ray(-32768, 32767, -32768, 32767, -32768, 32767, 65535),
              0, 0, 0, 0, 0);
      add_row(make_ray(32767, -32768, 0, 32767, 32767, 0, 1), 0, 0, 0, 0, 0);
      // dot above one gets clipped; grazing ray; total internal reflection
      add_row(make_ray(-8192, 0, 0, 8192, 0, 0, 4096), 0, 0, 0, 0, 0);
      add_row(make_ray(4096, 0, -1, 0, 0, 4096, 4096), 0, 0, 0, 0, 0);
      add_row(make_ray(2896, 0, -2896, 0, 0, 4096, 8192), 0, 0, 0, 0, 0);
      add_row(make_ray(2896, 0, -2896, 0, 0, 4096, 3072), 0, 0, 0, 0, 0);
      // ray leaving from the back of the surface
      add_row(make_ray(0, 2896, 2896, 0, 0, 4096, 6144), 0, 0, 0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].bent);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle = idle_set[ph];
         recv_stall = stall_set[ph];
         // long receiver hold so the pipe fills and backs up
         if (ph == 0) fork hold_off(300); join_none
         for (int k = 0; k < RandomRays / 4; k++) begin
            send_ray(random_ray(), 0, none);
            // sender pause until all outstanding beats are back
            if (ph == 3 && k == 100) drain();
         end
         drain();
      end

      repeat (DrainWait) @(posedge clock);
      if (mismatches == 0 && bent_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
